// ===== hdl/lpbd_pkg.sv =====
// Shared constants, types and helpers of the page buffer directory.
// Depends on nothing; lpbd_scan and the top level use it.
package lpbd_pkg;

  localparam int SLOTS      = 16;
  localparam int AGE_BITS   = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int TABLE_W    = 8;
  localparam int PAGE_W     = 16;
  localparam int TAG_W      = TABLE_W + PAGE_W;
  localparam int OUT_SLOT_W = 4;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PIN   = 2'd2,
    OP_UNPIN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Touch that still has to be applied to the age memory on the next scan.
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
  } pend_t;

  // Summary of one full scan over the slots.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              inv_found;
    logic [SLOT_W-1:0] inv_idx;
    logic              old_found;
    logic [SLOT_W-1:0] old_idx;
    logic [TAG_W-1:0]  old_tag;
  } scan_res_t;

  function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[OUT_SLOT_W-1:0];
  endfunction

endpackage

// ===== hdl/lpbd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module lpbd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lpbd_scan.sv =====
// Per-slot scan datapath: applies the pending touch to each age read back,
// and accumulates the tag hit and the victim candidates. Uses lpbd_pkg.
module lpbd_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr,
  input  logic                           proc,
  input  logic [lpbd_pkg::SLOT_W-1:0]    proc_idx,
  input  logic [lpbd_pkg::TAG_W-1:0]     req_tag,
  input  logic [lpbd_pkg::TAG_W-1:0]     tag_rd,
  input  logic [lpbd_pkg::AGE_BITS-1:0]  age_rd,
  input  logic                           slot_valid,
  input  logic                           slot_pinned,
  input  lpbd_pkg::pend_t                pend,
  output logic [lpbd_pkg::AGE_BITS-1:0]  age_wr,
  output lpbd_pkg::scan_res_t            res
);

  lpbd_pkg::scan_res_t           res_r, res_nxt;
  logic [lpbd_pkg::AGE_BITS-1:0] old_age_r, old_age_nxt;
  logic                          match;

  // Age as it stands once the previous request's touch is applied.
  always_comb begin
    if (!pend.vld) begin
      age_wr = age_rd;
    end else if (pend.idx == proc_idx) begin
      age_wr = '0;
    end else if (age_rd == lpbd_pkg::AGE_MAX) begin
      age_wr = age_rd;
    end else begin
      age_wr = age_rd + 1'b1;
    end
  end

  assign match = slot_valid && (tag_rd == req_tag);

  always_comb begin
    res_nxt     = res_r;
    old_age_nxt = old_age_r;
    if (clr) begin
      res_nxt.hit       = 1'b0;
      res_nxt.inv_found = 1'b0;
      res_nxt.old_found = 1'b0;
    end else if (proc) begin
      if (match && !res_r.hit) begin
        res_nxt.hit     = 1'b1;
        res_nxt.hit_idx = proc_idx;
      end
      if (!slot_pinned && !slot_valid && !res_r.inv_found) begin
        res_nxt.inv_found = 1'b1;
        res_nxt.inv_idx   = proc_idx;
      end
      // Strictly greater keeps the lowest index among equal ages.
      if (!slot_pinned && slot_valid && (!res_r.old_found || age_wr > old_age_r)) begin
        res_nxt.old_found = 1'b1;
        res_nxt.old_idx   = proc_idx;
        res_nxt.old_tag   = tag_rd;
        old_age_nxt       = age_wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r     <= '0;
      old_age_r <= '0;
    end else begin
      res_r     <= res_nxt;
      old_age_r <= old_age_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hdl/lru_page_buffer_directory_core.sv =====
// Top level of the LRU page buffer directory.
// Uses lpbd_pkg, lpbd_ram (tag and age memories) and lpbd_scan.
//
// Usage: each input transaction (in_op, in_table_id, in_page_number) is a
// read, write, pin or unpin of one page. Exactly one result transaction
// follows, giving hit, the slot, fetch/direct-write/writeback actions and
// the victim page to write back. Both channels use valid/ready.
//
// Timing: after acceptance the block walks all SLOTS slots through the tag
// and age memories (one read per cycle, registered read data), then decides
// as soon as the output register is free. The result is registered, and a
// new transaction is accepted only after the previous decision is made;
// the slot walk over the single read port of each memory sets this pace.
// Aging is lazy: the touch of a request is written into the age memory
// during the next request's walk, read-modify-write per slot.
//
// Reset clears valid, dirty and pinned flags and the pending touch; the
// memories need no clearing, as an invalid slot is never matched and its
// age is zeroed before it is ever compared. When the receiver stalls, the
// result waits in the output register while the next transaction is already
// accepted and scanned; its decision then waits until the register is free.
module lru_page_buffer_directory_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_table_id,
  input  logic [15:0] in_page_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_slot_used,
  output logic [3:0]  out_slot,
  output logic        out_fetch_page,
  output logic        out_write_direct,
  output logic        out_writeback,
  output logic [7:0]  out_victim_table,
  output logic [15:0] out_victim_page,
  output logic        out_found
);

  localparam int SLOTS  = lpbd_pkg::SLOTS;
  localparam int SLOT_W = lpbd_pkg::SLOT_W;
  localparam int CNT_W  = lpbd_pkg::CNT_W;
  localparam int TAG_W  = lpbd_pkg::TAG_W;
  localparam int AGE_W  = lpbd_pkg::AGE_BITS;

  lpbd_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  lpbd_pkg::op_t     op_r;
  logic [7:0]        tab_r;
  logic [15:0]       pg_r;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  dirty_r, dirty_nxt;
  logic [SLOTS-1:0]  pinned_r, pinned_nxt;
  lpbd_pkg::pend_t   pend_r, pend_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r, out_slot_used_r, out_fetch_page_r, out_write_direct_r;
  logic        out_writeback_r, out_found_r;
  logic [3:0]  out_slot_r;
  logic [7:0]  out_victim_table_r;
  logic [15:0] out_victim_page_r;

  logic              accept, fire, rd_en, proc, age_we;
  logic [SLOT_W-1:0] rd_addr, proc_idx;
  logic [TAG_W-1:0]  tag_rd, req_tag;
  logic [AGE_W-1:0]  age_rd, age_wr;
  lpbd_pkg::scan_res_t res;

  // Decision of the current request.
  logic              is_pin, v_found, install, touch, wb;
  logic [SLOT_W-1:0] v_idx, touch_idx;

  assign in_ready = (state_r == lpbd_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign req_tag  = {tab_r, pg_r};

  // Memory read issue for slot cnt_r; the data of slot cnt_r-1 is processed.
  assign rd_en    = (state_r == lpbd_pkg::ST_SCAN) && (cnt_r < CNT_W'(SLOTS));
  assign rd_addr  = cnt_r[SLOT_W-1:0];
  assign proc     = (state_r == lpbd_pkg::ST_SCAN) && (cnt_r != '0);
  assign proc_idx = SLOT_W'(cnt_r - 1'b1);
  assign age_we   = proc;

  assign fire = (state_r == lpbd_pkg::ST_DONE) && (!out_valid_r || out_ready);

  lpbd_ram #(.DEPTH(SLOTS), .WIDTH(TAG_W)) u_tag_ram (
    .clk   (clk),
    .we    (fire && install),
    .waddr (v_idx),
    .wdata (req_tag),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  lpbd_ram #(.DEPTH(SLOTS), .WIDTH(AGE_W)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (proc_idx),
    .wdata (age_wr),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (age_rd)
  );

  lpbd_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (accept),
    .proc        (proc),
    .proc_idx    (proc_idx),
    .req_tag     (req_tag),
    .tag_rd      (tag_rd),
    .age_rd      (age_rd),
    .slot_valid  (valid_r[proc_idx]),
    .slot_pinned (pinned_r[proc_idx]),
    .pend        (pend_r),
    .age_wr      (age_wr),
    .res         (res)
  );

  // The victim is the first free unpinned slot, else the oldest unpinned one.
  always_comb begin
    is_pin    = op_r[1];
    v_found   = res.inv_found || res.old_found;
    v_idx     = res.inv_found ? res.inv_idx : res.old_idx;
    install   = !is_pin && !res.hit && v_found;
    touch     = !is_pin && (res.hit || v_found);
    touch_idx = res.hit ? res.hit_idx : v_idx;
    wb        = install && valid_r[v_idx] && dirty_r[v_idx];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    pinned_nxt    = pinned_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      lpbd_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = lpbd_pkg::ST_SCAN;
        end
      end
      lpbd_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SLOTS)) begin
          state_nxt = lpbd_pkg::ST_DONE;
        end
      end
      lpbd_pkg::ST_DONE: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          state_nxt     = lpbd_pkg::ST_IDLE;
          // The walk just finished applied the old touch.
          pend_nxt.vld  = touch;
          pend_nxt.idx  = touch_idx;
          if (is_pin) begin
            if (res.hit) begin
              pinned_nxt[res.hit_idx] = (op_r == lpbd_pkg::OP_PIN);
            end
          end else if (res.hit) begin
            if (op_r == lpbd_pkg::OP_WRITE) begin
              dirty_nxt[res.hit_idx] = 1'b1;
            end
          end else if (v_found) begin
            valid_nxt[v_idx]  = 1'b1;
            dirty_nxt[v_idx]  = (op_r == lpbd_pkg::OP_WRITE);
            pinned_nxt[v_idx] = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = lpbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpbd_pkg::ST_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      pinned_r    <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      pinned_r    <= pinned_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= lpbd_pkg::op_t'(in_op);
      tab_r <= in_table_id;
      pg_r  <= in_page_number;
    end
    if (fire) begin
      out_hit_r          <= res.hit;
      out_found_r        <= is_pin && res.hit;
      out_slot_used_r    <= res.hit || install;
      out_slot_r         <= res.hit ? lpbd_pkg::slot_out(res.hit_idx) :
                            (install ? lpbd_pkg::slot_out(v_idx) : '0);
      out_fetch_page_r   <= !res.hit && (op_r == lpbd_pkg::OP_READ);
      out_write_direct_r <= !res.hit && !v_found && (op_r == lpbd_pkg::OP_WRITE);
      out_writeback_r    <= wb;
      out_victim_table_r <= wb ? res.old_tag[TAG_W-1:lpbd_pkg::PAGE_W] : '0;
      out_victim_page_r  <= wb ? res.old_tag[lpbd_pkg::PAGE_W-1:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot_used    = out_slot_used_r;
  assign out_slot         = out_slot_r;
  assign out_fetch_page   = out_fetch_page_r;
  assign out_write_direct = out_write_direct_r;
  assign out_writeback    = out_writeback_r;
  assign out_victim_table = out_victim_table_r;
  assign out_victim_page  = out_victim_page_r;
  assign out_found        = out_found_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpbd_pkg::ST_SCAN) |-> (cnt_r <= CNT_W'(SLOTS)))
    else $error("slot walk counter ran past the last slot");

  a_wb_install: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_writeback_r) |-> (out_slot_used_r && !out_hit_r))
    else $error("writeback reported without an install");

  a_found_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_hit_r && out_slot_used_r))
    else $error("found reported without a hit slot");

  a_touch_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && touch) |=> (pend_r.vld && state_r == lpbd_pkg::ST_IDLE))
    else $error("touch of a request was not recorded");

  a_act_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_fetch_page_r && out_write_direct_r))
    else $error("fetch and direct write reported together");

endmodule
